// ===== rtl/wsc_pkg.sv =====
// Shared types, constants and helper functions of the wiper sweep controller.
// Depends on nothing; every other file of the block imports it.
package wsc_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int DUTY_BITS     = 13;
    localparam int SAMPLE_W      = 12;
    localparam int THR_W         = 13;
    localparam int STEP_W        = 16;
    localparam int PAUSE_W       = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = (DUTY_BITS > STEP_W) ? DUTY_BITS : STEP_W;

    // Magnitude must hold duty_max in fixed point plus one full step; one more bit for sign.
    localparam int MAG_W   = ((DUTY_BITS + FRACTION_BITS) > STEP_W ?
                              (DUTY_BITS + FRACTION_BITS) : STEP_W) + 1;
    localparam int POS_W   = MAG_W + 1;
    localparam int POS_PAD = POS_W - DUTY_BITS - FRACTION_BITS;

    localparam logic [DUTY_BITS-1:0] RST_DUTY_MIN  = DUTY_BITS'(220);
    localparam logic [DUTY_BITS-1:0] RST_DUTY_MAX  = DUTY_BITS'(590);
    localparam logic [STEP_W-1:0]    RST_STEP_SLOW = STEP_W'(630);
    localparam logic [STEP_W-1:0]    RST_STEP_FAST = STEP_W'(1562);
    localparam logic [THR_W-1:0]     RST_THR_INT   = THR_W'(1024);
    localparam logic [THR_W-1:0]     RST_THR_LOW   = THR_W'(2048);
    localparam logic [THR_W-1:0]     RST_THR_HIGH  = THR_W'(3072);
    localparam logic [PAUSE_W-1:0]   RST_PAUSE     = PAUSE_W'(100);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_UP    = 2'd1,
        PH_DOWN  = 2'd2,
        PH_PAUSE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_INTERVAL = 2'd1,
        MODE_LOW      = 2'd2,
        MODE_HIGH     = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_MIN  = 3'd0,
        CFG_DUTY_MAX  = 3'd1,
        CFG_STEP_SLOW = 3'd2,
        CFG_STEP_FAST = 3'd3,
        CFG_THR_INT   = 3'd4,
        CFG_THR_LOW   = 3'd5,
        CFG_THR_HIGH  = 3'd6,
        CFG_PAUSE     = 3'd7
    } cfg_idx_t;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty_min;
        logic [DUTY_BITS-1:0] duty_max;
        logic [STEP_W-1:0]    step_slow;
        logic [STEP_W-1:0]    step_fast;
        logic [THR_W-1:0]     thr_int;
        logic [THR_W-1:0]     thr_low;
        logic [THR_W-1:0]     thr_high;
        logic [PAUSE_W-1:0]   pause_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        mode_t              mode;
        pos_t               pos;
        logic [PAUSE_W-1:0] pause_left;
    } sweep_state_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        phase_t               phase;
        mode_t                mode;
    } result_t;

    function automatic mode_t classify(input logic [SAMPLE_W-1:0] sample, input cfg_t cfg);
        logic [THR_W-1:0] s;
        s = THR_W'(sample);
        if (s < cfg.thr_int)       return MODE_OFF;
        else if (s < cfg.thr_low)  return MODE_INTERVAL;
        else if (s < cfg.thr_high) return MODE_LOW;
        else                       return MODE_HIGH;
    endfunction

    // zero step is taken as one
    function automatic pos_t step_of(input mode_t mode, input cfg_t cfg);
        logic [STEP_W-1:0] s;
        s = (mode == MODE_HIGH) ? cfg.step_fast : cfg.step_slow;
        if (s == '0) s = STEP_W'(1);
        return {{(POS_W-STEP_W){1'b0}}, s};
    endfunction

    // down count: any borrow parks at -1
    function automatic pos_t step_down(input pos_t pos, input pos_t step);
        pos_t d;
        d = pos - step;
        if (d[POS_W-1]) d = '1;
        return d;
    endfunction

    function automatic logic [DUTY_BITS-1:0] duty_of(input pos_t pos);
        return pos[FRACTION_BITS +: DUTY_BITS];
    endfunction

    function automatic pos_t to_pos(input logic [DUTY_BITS-1:0] d);
        return {{POS_PAD{1'b0}}, d, {FRACTION_BITS{1'b0}}};
    endfunction

endpackage

// ===== rtl/wiper_sweep_controller.sv =====
// Wiper sweep controller: one input word is one 10 ms tick with a mode-knob sample,
// each tick returns one result word (servo duty, phase, mode). A word is accepted every
// cycle when the output side keeps up; its result passes through the input register, then
// the result register. The sustained rate of one word per cycle, when the output side keeps
// up, is set by the combinational update of the sweep state between the two registers.
// No clearing pass after reset. Depends on wsc_pkg, wsc_cfg_regs and wsc_tick_logic.
module wiper_sweep_controller (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [wsc_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [wsc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [wsc_pkg::SAMPLE_W-1:0]    s_knob_sample,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [wsc_pkg::DUTY_BITS-1:0]   m_duty,
    output logic [1:0]                      m_phase_now,
    output logic [1:0]                      m_active_mode
);
    import wsc_pkg::*;

    cfg_t                cfg;
    sweep_state_t        state_reg;
    sweep_state_t        state_next;
    result_t             res_next;
    result_t             res_reg;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                out_valid_reg;
    logic                advance;

    wsc_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    wsc_tick_logic u_tick (
        .cfg    (cfg),
        .st     (state_reg),
        .sample (sample_reg),
        .nxt    (state_next),
        .res    (res_next)
    );

    // word in the input register moves on when the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg.phase      <= PH_IDLE;
            state_reg.mode       <= MODE_OFF;
            state_reg.pos        <= '0;
            state_reg.pause_left <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_knob_sample;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_duty        = res_reg.duty;
    assign m_phase_now   = res_reg.phase;
    assign m_active_mode = res_reg.mode;

    // idle and pause ticks drive the servo at zero duty
    a_rest_duty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_phase_now == PH_IDLE || m_phase_now == PH_PAUSE) |-> m_duty == '0)
        else $error("nonzero duty outside a sweep");

    // a running sweep or pause never carries the off mode
    a_active_not_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_phase_now != PH_IDLE |-> m_active_mode != MODE_OFF)
        else $error("sweep reported in off mode");

    // pause phase always has ticks left to count
    a_pause_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_PAUSE |-> state_reg.pause_left != '0)
        else $error("pause phase with empty counter");

    // a waiting input word is neither dropped nor overwritten
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(sample_reg))
        else $error("input word lost while stalled");

endmodule

// ===== rtl/wsc_cfg_regs.sv =====
// Configuration register file of the wiper sweep controller.
// Depends on wsc_pkg for register indexes, widths and reset values.
module wsc_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [wsc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [wsc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output wsc_pkg::cfg_t                cfg
);
    import wsc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                CFG_DUTY_MIN:  cfg_next.duty_min    = cfg_wr_data[DUTY_BITS-1:0];
                CFG_DUTY_MAX:  cfg_next.duty_max    = cfg_wr_data[DUTY_BITS-1:0];
                CFG_STEP_SLOW: cfg_next.step_slow   = cfg_wr_data[STEP_W-1:0];
                CFG_STEP_FAST: cfg_next.step_fast   = cfg_wr_data[STEP_W-1:0];
                CFG_THR_INT:   cfg_next.thr_int     = cfg_wr_data[THR_W-1:0];
                CFG_THR_LOW:   cfg_next.thr_low     = cfg_wr_data[THR_W-1:0];
                CFG_THR_HIGH:  cfg_next.thr_high    = cfg_wr_data[THR_W-1:0];
                CFG_PAUSE:     cfg_next.pause_ticks = cfg_wr_data[PAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.duty_min    <= RST_DUTY_MIN;
            cfg_reg.duty_max    <= RST_DUTY_MAX;
            cfg_reg.step_slow   <= RST_STEP_SLOW;
            cfg_reg.step_fast   <= RST_STEP_FAST;
            cfg_reg.thr_int     <= RST_THR_INT;
            cfg_reg.thr_low     <= RST_THR_LOW;
            cfg_reg.thr_high    <= RST_THR_HIGH;
            cfg_reg.pause_ticks <= RST_PAUSE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/wsc_tick_logic.sv =====
// Per-tick next-state and result logic of the wiper sweep (combinational).
// Depends on wsc_pkg for the state, result and configuration types.
module wsc_tick_logic (
    input  wsc_pkg::cfg_t                     cfg,
    input  wsc_pkg::sweep_state_t             st,
    input  logic [wsc_pkg::SAMPLE_W-1:0]      sample,
    output wsc_pkg::sweep_state_t             nxt,
    output wsc_pkg::result_t                  res
);
    import wsc_pkg::*;

    pos_t               lo;
    pos_t               hi;
    pos_t               step_lat;
    pos_t               step_new;
    mode_t              m_new;
    logic [PAUSE_W-1:0] pause_first;
    logic               pause_on;
    logic               do_start;
    logic               do_exit;

    always_comb begin
        lo          = to_pos(cfg.duty_min);
        hi          = to_pos(cfg.duty_max);
        m_new       = classify(sample, cfg);
        step_lat    = step_of(st.mode, cfg);
        step_new    = step_of(m_new, cfg);
        pause_first = cfg.pause_ticks - PAUSE_W'(1);
        pause_on    = (cfg.pause_ticks != '0);

        nxt       = st;
        res.duty  = '0;
        res.phase = PH_IDLE;
        res.mode  = st.mode;
        do_start  = 1'b0;
        do_exit   = 1'b0;

        case (st.phase)
            PH_IDLE: do_start = 1'b1;
            PH_UP: begin
                if (st.pos <= hi) begin
                    res.duty  = duty_of(st.pos);
                    res.phase = PH_UP;
                    nxt.pos   = st.pos + step_lat;
                end else begin
                    // top reached: down from duty_max this tick; exit if duty_max < duty_min
                    nxt.pos = hi;
                    if (hi >= lo) begin
                        res.duty  = duty_of(hi);
                        res.phase = PH_DOWN;
                        nxt.phase = PH_DOWN;
                        nxt.pos   = step_down(hi, step_lat);
                    end else begin
                        do_exit = 1'b1;
                    end
                end
            end
            PH_DOWN: begin
                // pos parked at -1 fails this since lo is never negative
                if (st.pos >= lo) begin
                    res.duty  = duty_of(st.pos);
                    res.phase = PH_DOWN;
                    nxt.pos   = step_down(st.pos, step_lat);
                end else begin
                    do_exit = 1'b1;
                end
            end
            default: begin
                if (st.pause_left != '0) begin
                    nxt.pause_left = st.pause_left - PAUSE_W'(1);
                    nxt.phase      = (nxt.pause_left == '0) ? PH_IDLE : PH_PAUSE;
                    res.phase      = PH_PAUSE;
                end else begin
                    do_start = 1'b1;
                end
            end
        endcase

        // sweep finished: pause after interval sweeps when a pause is set, else back to idle and reclassify
        if (do_exit) begin
            if (st.mode == MODE_INTERVAL && pause_on) begin
                nxt.pause_left = pause_first;
                nxt.phase      = (pause_first == '0) ? PH_IDLE : PH_PAUSE;
                res.phase      = PH_PAUSE;
            end else begin
                do_start = 1'b1;
            end
        end

        // classify at most once per tick
        if (do_start) begin
            nxt.mode  = m_new;
            nxt.phase = PH_IDLE;
            res.mode  = m_new;
            res.duty  = '0;
            res.phase = PH_IDLE;
            if (m_new != MODE_OFF) begin
                if (lo <= hi) begin
                    res.duty  = duty_of(lo);
                    res.phase = PH_UP;
                    nxt.phase = PH_UP;
                    nxt.pos   = lo + step_new;
                end else begin
                    // empty sweep
                    nxt.pos = hi;
                    if (m_new == MODE_INTERVAL && pause_on) begin
                        nxt.pause_left = pause_first;
                        nxt.phase      = (pause_first == '0) ? PH_IDLE : PH_PAUSE;
                        res.phase      = PH_PAUSE;
                    end
                end
            end
        end
    end

endmodule
